// ===== sv/qpsd_pkg.sv =====
// Quoted-printable stream decoder: shared types, character constants and
// the hex digit lookup. No dependencies; used by every module of the block.
`default_nettype none

package qpsd_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ESCAPE_IS_PERCENT = 1'b0,
    CFG_Q_MODE            = 1'b1
  } cfg_idx_t;

  // Input item kinds (carried on tuser)
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOS  = 1'b1
  } kind_t;

  // Character codes
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_TILDE      = 8'h7E;

  // Most results one item can cause
  localparam int MaxRes = 3;
  localparam int CntW   = 2;

  // Active configuration
  typedef struct packed {
    logic esc_pct;
    logic q_mode;
  } cfg_t;

  // Results of one item, first result in slot 0
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    logic [MaxRes-1:0][7:0]   data;
  } res_t;

  // Hex digit value; bit 4 set when ch is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
      r = {1'b0, d[3:0]};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      d = ch - 8'h37;
      r = {1'b0, d[3:0]};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      d = ch - 8'h57;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/quoted_printable_stream_decoder.sv =====
// Quoted-printable stream decoder top level: input register, config
// registers, decoder core and result register. Depends on qpsd_pkg,
// qpsd_decode and qpsd_outbuf.
//
// Takes one encoded byte per input transaction (tuser 1 = end-of-stream
// flush) and gives decoded bytes, tlast marking the final byte caused by
// each input item. Items causing zero or one byte stream at one per cycle
// while out_tready is high, via the input and result registers; an item
// causing two or three bytes (escape flushes) holds the input while the
// three-byte result register drains through the single output port.
// Configuration (index 0: escape is '%', index 1: Q mode) must be written
// only while the block is idle (not enforced); cfg_ready is always high.
`default_nettype none

module quoted_printable_stream_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [qpsd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic                         cfg_data,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // [7:0] in_byte
  input  wire logic                         in_tuser,   // [0] kind
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] out_byte
  output logic                              out_tlast
);
  import qpsd_pkg::*;

  cfg_t       cfg_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       in_acc;
  logic       ob_free;
  res_t       res;

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ESCAPE_IS_PERCENT: cfg_r.esc_pct <= cfg_data;
        CFG_Q_MODE:            cfg_r.q_mode  <= cfg_data;
        default:               cfg_r         <= cfg_r;
      endcase
    end
  end

  // Input register
  assign s1_adv       = s1_valid_r && (res.cnt == '0 || ob_free);
  assign in_tready    = !s1_valid_r || s1_adv;
  assign in_acc       = in_tvalid && in_tready;
  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
    if (in_acc) begin
      s1_kind_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  qpsd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item_kind (s1_kind_r),
    .item_byte (s1_byte_r),
    .adv       (s1_adv),
    .res       (res)
  );

  qpsd_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (s1_adv && res.cnt != '0),
    .res        (res),
    .free       (ob_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A stuck item blocks new input
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_tready) else $error("input overrun");

  // An item that moves on with results leaves output pending
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res.cnt != '0) |=> out_tvalid) else $error("results lost");

  // An item not moving on stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("held item changed");

endmodule

`default_nettype wire

// ===== sv/qpsd_decode.sv =====
// Decoder core: escape / soft break / CR state and the per-item result set.
// Depends on qpsd_pkg. State advances only when the held item moves on.
`default_nettype none

module qpsd_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire qpsd_pkg::cfg_t cfg,
  input  wire logic          item_kind,
  input  wire logic [7:0]    item_byte,
  input  wire logic          adv,
  output qpsd_pkg::res_t     res
);
  import qpsd_pkg::*;

  logic       ine_r, ine_nxt;
  logic       hn_r, hn_nxt;
  logic [3:0] hnib_r, hnib_nxt;
  logic [7:0] held_r, held_nxt;
  logic       elf_r, elf_nxt;

  // Result set and next state for the held item
  always_comb begin
    logic [7:0] esc;
    logic [7:0] ch;
    logic [4:0] hv;
    logic       ine_e;
    esc      = cfg.esc_pct ? CH_PERCENT : CH_EQUALS;
    ch       = item_byte;
    hv       = hex_val(ch);
    ine_e    = ine_r;
    ine_nxt  = ine_r;
    hn_nxt   = hn_r;
    hnib_nxt = hnib_r;
    held_nxt = held_r;
    elf_nxt  = elf_r;
    res.cnt  = '0;
    res.data = '0;
    if (item_kind == KIND_EOS) begin
      // flush open escape, then held hex char
      if (ine_r) begin
        res.data[0] = esc;
        if (hn_r) begin
          res.data[1] = held_r;
          res.cnt     = 2'd2;
        end else begin
          res.cnt = 2'd1;
        end
      end else if (hn_r) begin
        res.data[0] = held_r;
        res.cnt     = 2'd1;
      end
      ine_nxt  = 1'b0;
      hn_nxt   = 1'b0;
      hnib_nxt = '0;
      held_nxt = '0;
      elf_nxt  = 1'b0;
    end else begin
      // CR not followed by LF cancels the pending soft break
      if (elf_r && ch != CH_LF) begin
        ine_e   = 1'b0;
        elf_nxt = 1'b0;
      end
      ine_nxt = ine_e;
      if (ine_e) begin
        if (!hv[4]) begin
          if (hn_r) begin
            res.data[0] = {hnib_r, hv[3:0]};
            res.cnt     = 2'd1;
            hn_nxt      = 1'b0;
            hnib_nxt    = '0;
            ine_nxt     = 1'b0;
          end else begin
            hn_nxt   = 1'b1;
            hnib_nxt = hv[3:0];
            held_nxt = ch;
          end
        end else if (!hn_r && ch == CH_CR) begin
          elf_nxt = 1'b1;
        end else if (!hn_r && ch == CH_LF) begin
          // soft line break
          ine_nxt = 1'b0;
          elf_nxt = 1'b0;
        end else begin
          // bad byte: escape, held char, then the byte itself unless it is NUL or the escape
          res.data[0] = esc;
          if (hn_r) begin
            res.data[1] = held_r;
            res.cnt     = 2'd2;
          end else begin
            res.cnt = 2'd1;
          end
          if (ch != esc && ch != CH_NUL) begin
            if (hn_r) res.data[2] = ch;
            else      res.data[1] = ch;
            res.cnt = res.cnt + 2'd1;
          end
          hn_nxt   = 1'b0;
          hnib_nxt = '0;
          elf_nxt  = 1'b0;
          ine_nxt  = (ch == esc);
        end
      end else begin
        if ((ch >= CH_SPACE && ch <= CH_TILDE) || ch == CH_TAB) begin
          if (ch == esc) begin
            ine_nxt = 1'b1;
          end else if (cfg.q_mode && ch == CH_UNDERSCORE) begin
            res.data[0] = CH_SPACE;
            res.cnt     = 2'd1;
          end else begin
            res.data[0] = ch;
            res.cnt     = 2'd1;
          end
        end else if (ch == CH_LF) begin
          res.data[0] = CH_LF;
          res.cnt     = 2'd1;
          elf_nxt     = 1'b0;
        end else if (ch == CH_CR) begin
          elf_nxt = 1'b1;
        end else begin
          res.data[0] = ch;
          res.cnt     = 2'd1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ine_r  <= 1'b0;
      hn_r   <= 1'b0;
      hnib_r <= '0;
      held_r <= '0;
      elf_r  <= 1'b0;
    end else if (adv) begin
      ine_r  <= ine_nxt;
      hn_r   <= hn_nxt;
      hnib_r <= hnib_nxt;
      held_r <= held_nxt;
      elf_r  <= elf_nxt;
    end
  end

  // A held hex digit only exists inside an escape
  a_hn_in_esc: assert property (@(posedge clk) disable iff (!rst_n)
    hn_r |-> ine_r) else $error("held digit outside escape");

  // Pending LF never coexists with a held digit
  a_elf_no_hn: assert property (@(posedge clk) disable iff (!rst_n)
    elf_r |-> !hn_r) else $error("expect LF with held digit");

  // End of stream clears all decode state
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_kind == KIND_EOS) |=> (!ine_r && !hn_r && !elf_r))
    else $error("end of stream left state behind");

endmodule

`default_nettype wire

// ===== sv/qpsd_outbuf.sv =====
// Result register: holds up to three decoded bytes of one item and hands
// them out one per transaction. Depends on qpsd_pkg.
`default_nettype none

module qpsd_outbuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           ld,
  input  wire qpsd_pkg::res_t res,
  output logic                free,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,   // [7:0] out_byte
  output logic                out_tlast
);
  import qpsd_pkg::*;

  logic [MaxRes-1:0][7:0] data_r, data_nxt;
  logic [CntW-1:0]        rem_r, rem_nxt;
  logic                   take;

  assign take       = out_tvalid && out_tready;
  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = data_r[0];
  assign out_tlast  = (rem_r == 2'd1);
  assign free       = (rem_r == '0) || (rem_r == 2'd1 && take);

  // Load a new set or shift the head out
  always_comb begin
    data_nxt = data_r;
    rem_nxt  = rem_r;
    if (ld) begin
      data_nxt = res.data;
      rem_nxt  = res.cnt;
    end else if (take) begin
      data_nxt = {8'h00, data_r[MaxRes-1:1]};
      rem_nxt  = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) rem_r <= '0;
    else        rem_r <= rem_nxt;
  end

  // Never load over bytes still waiting
  a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> free) else $error("result set overwritten");

  // A load leaves exactly its count pending
  a_ld_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ld |=> rem_r == $past(res.cnt)) else $error("bad count after load");

  // A transaction without load drops exactly one byte
  a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !ld) |=> rem_r == $past(rem_r) - 2'd1)
    else $error("bad count after transaction");

endmodule

`default_nettype wire
